FILE: sv/sct_pkg.sv
// sct_pkg: shared types, widths and geometry helpers for the segment crossing test
// depends on nothing; used by sct_pair_if, segment_crossing_test, sct_orient and the bench
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

  // coordinate and arithmetic widths
  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // orientation classes of a cross product
  typedef enum logic [1:0] {
    ORIENT_ZERO,
    ORIENT_POS,
    ORIENT_NEG
  } orient_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    point_t a0;
    point_t a1;
    point_t b0;
    point_t b1;
  } seg_pair_t;

  // m strictly between a and b, or all three equal
  function automatic logic axis_inside(coord_t a, coord_t m, coord_t b);
    coord_t lo;
    coord_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return ((m > lo) && (m < hi)) || ((m == lo) && (m == hi));
  endfunction

  // point m strictly inside segment a-b, axis by axis
  function automatic logic point_inside(point_t a, point_t m, point_t b);
    return axis_inside(a.x, m.x, b.x) && axis_inside(a.y, m.y, b.y);
  endfunction

endpackage

`default_nettype wire

FILE: sv/sct_pair_if.sv
// sct_pair_if: valid/ready channel carrying one pair of segments
// depends on sct_pkg for the coordinate type
`timescale 1ns / 1ps
`default_nettype none

interface sct_pair_if;
  logic            valid;
  logic            ready;
  sct_pkg::coord_t a_start_x;
  sct_pkg::coord_t a_start_y;
  sct_pkg::coord_t a_end_x;
  sct_pkg::coord_t a_end_y;
  sct_pkg::coord_t b_start_x;
  sct_pkg::coord_t b_start_y;
  sct_pkg::coord_t b_end_x;
  sct_pkg::coord_t b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
    output b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
    input  b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/sct_result_if.sv
// sct_result_if: valid/ready channel carrying the one-bit overlap verdict
// no package dependency
`timescale 1ns / 1ps
`default_nettype none

interface sct_result_if;
  logic valid;
  logic ready;
  logic segments_overlap;

  modport source (output valid, segments_overlap, input ready);
  modport sink (input valid, segments_overlap, output ready);
endinterface

`default_nettype wire

FILE: sv/segment_crossing_test.sv
// segment_crossing_test: top level of the strict segment overlap test
// depends on sct_pkg, sct_pair_if, sct_result_if and sct_orient
//
// Usage:
//   pair   : sink channel, one pair of segments A and B per transaction,
//            signed 16-bit endpoint coordinates.
//   result : source channel, one segments_overlap bit per pair, in order.
//   A pair is registered on acceptance, evaluated by the four orientation
//   units and the decision logic in the following cycle, and the verdict is
//   registered into the result stage, which drives result valid. One pair is
//   accepted every cycle when the receiver keeps ready high. The critical path
//   is one 17x17 signed multiply followed by a 35-bit subtract and zero test
//   in the orientation units. When the receiver stalls, the verdict holds in
//   the result register and the input register still takes one more pair;
//   pair.ready then drops until the result transaction completes. Synchronous
//   reset empties both stages; no result is valid in the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module segment_crossing_test (
  input  logic                clk,
  input  logic                rst,
  sct_pair_if.sink            pair,
  sct_result_if.source        result
);
  import sct_pkg::*;

  seg_pair_t in_data;
  seg_pair_t pair_q;
  logic      pair_valid;
  logic      out_valid;
  logic      overlap_q;
  logic      out_load;
  logic      in_load;

  orient_t   s1, s2, s3, s4;
  logic      all_zero;
  logic      any_zero;
  logic      any_inside;
  logic      same_first;
  logic      same_second;
  logic      hit;

  // pack the incoming transaction
  assign in_data.a0 = '{x: pair.a_start_x, y: pair.a_start_y};
  assign in_data.a1 = '{x: pair.a_end_x,   y: pair.a_end_y};
  assign in_data.b0 = '{x: pair.b_start_x, y: pair.b_start_y};
  assign in_data.b1 = '{x: pair.b_end_x,   y: pair.b_end_y};

  // flow control: result stage frees when empty or taken
  assign out_load   = !out_valid || result.ready;
  assign in_load    = !pair_valid || out_load;
  assign pair.ready = in_load;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (in_load) begin
      pair_valid <= pair.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && pair.valid) begin
      pair_q <= in_data;
    end
  end

  // orientation of B's endpoints against A and A's endpoints against B
  sct_orient u_orient_1 (.p(pair_q.a0), .q(pair_q.a1), .r(pair_q.b0), .sign(s1));
  sct_orient u_orient_2 (.p(pair_q.a0), .q(pair_q.a1), .r(pair_q.b1), .sign(s2));
  sct_orient u_orient_3 (.p(pair_q.b0), .q(pair_q.b1), .r(pair_q.a0), .sign(s3));
  sct_orient u_orient_4 (.p(pair_q.b0), .q(pair_q.b1), .r(pair_q.a1), .sign(s4));

  // collinear overlap terms
  assign all_zero = (s1 == ORIENT_ZERO) && (s2 == ORIENT_ZERO) &&
                    (s3 == ORIENT_ZERO) && (s4 == ORIENT_ZERO);
  assign any_zero = (s1 == ORIENT_ZERO) || (s2 == ORIENT_ZERO) ||
                    (s3 == ORIENT_ZERO) || (s4 == ORIENT_ZERO);
  assign any_inside = point_inside(pair_q.a0, pair_q.b0, pair_q.a1) ||
                      point_inside(pair_q.a0, pair_q.b1, pair_q.a1) ||
                      point_inside(pair_q.b0, pair_q.a0, pair_q.b1) ||
                      point_inside(pair_q.b0, pair_q.a1, pair_q.b1);
  assign same_first  = (pair_q.a0 == pair_q.b0) || (pair_q.a0 == pair_q.b1);
  assign same_second = (pair_q.a1 == pair_q.b0) || (pair_q.a1 == pair_q.b1);

  // verdict: proper crossing, or collinear overlap
  always_comb begin
    if ((s1 != s2) && (s3 != s4)) begin
      hit = !any_zero;
    end else if (all_zero) begin
      hit = any_inside || (same_first && same_second);
    end else begin
      hit = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= pair_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && pair_valid) begin
      overlap_q <= hit;
    end
  end

  assign result.valid            = out_valid;
  assign result.segments_overlap = overlap_q;

endmodule

`default_nettype wire

FILE: sv/sct_orient.sv
// sct_orient: exact orientation class of point r against the directed line p-q
// depends on sct_pkg for widths, point and orientation types
`timescale 1ns / 1ps
`default_nettype none

module sct_orient (
  input  sct_pkg::point_t  p,
  input  sct_pkg::point_t  q,
  input  sct_pkg::point_t  r,
  output sct_pkg::orient_t sign
);
  import sct_pkg::*;

  logic signed [DIFF_BITS-1:0]  dy_pq;
  logic signed [DIFF_BITS-1:0]  dx_qr;
  logic signed [DIFF_BITS-1:0]  dx_pq;
  logic signed [DIFF_BITS-1:0]  dy_qr;
  logic signed [PROD_BITS-1:0]  prod_a;
  logic signed [PROD_BITS-1:0]  prod_b;
  logic signed [CROSS_BITS-1:0] cross_val;

  // edge vectors, one bit wider than a coordinate
  assign dy_pq = DIFF_BITS'(q.y) - DIFF_BITS'(p.y);
  assign dx_qr = DIFF_BITS'(r.x) - DIFF_BITS'(q.x);
  assign dx_pq = DIFF_BITS'(q.x) - DIFF_BITS'(p.x);
  assign dy_qr = DIFF_BITS'(r.y) - DIFF_BITS'(q.y);

  // cross product (qy-py)*(rx-qx) - (qx-px)*(ry-qy), exact
  assign prod_a    = PROD_BITS'(dy_pq) * PROD_BITS'(dx_qr);
  assign prod_b    = PROD_BITS'(dx_pq) * PROD_BITS'(dy_qr);
  assign cross_val = CROSS_BITS'(prod_a) - CROSS_BITS'(prod_b);

  // classify the sign
  always_comb begin
    if (cross_val == '0) begin
      sign = ORIENT_ZERO;
    end else if (cross_val[CROSS_BITS-1]) begin
      sign = ORIENT_NEG;
    end else begin
      sign = ORIENT_POS;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sct_checker.sv
// sct_checker: port-level timing checks for segment_crossing_test
// depends on segment_crossing_test and its channel interfaces (bound below)
`timescale 1ns / 1ps
`default_nettype none

module sct_checker (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  logic out_valid,
  input  logic out_ready,
  input  logic overlap
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its verdict
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(overlap))
    else $error("result changed while stalled");

  // nothing offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // an empty result stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result stage");

  // an accepted pair reaches the result stage when the receiver does not stall
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted pair did not reach the result stage");

endmodule

bind segment_crossing_test sct_checker u_sct_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pair.valid),
  .in_ready  (pair.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .overlap   (result.segments_overlap)
);

`default_nettype wire

FILE: test/segment_crossing_test_tb.sv
// segment_crossing_test_tb: self-checking bench for the strict segment overlap test
// depends on sct_pkg, sct_pair_if, sct_result_if and the segment_crossing_test top level
// predicts each verdict from exact 64-bit orientation signs and checks results in order
`timescale 1ns / 1ps

module segment_crossing_test_tb;
  import sct_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 4;
  localparam int CORNER_VALUES [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

  typedef struct {
    seg_pair_t pair;
    logic      overlap;
  } overlap_expect_t;

  logic clk = 1'b0;
  logic rst;

  sct_pair_if   pair_ch ();
  sct_result_if result_ch ();

  segment_crossing_test u_top (
    .clk    (clk),
    .rst    (rst),
    .pair   (pair_ch),
    .result (result_ch)
  );

  overlap_expect_t overlap_expect_q [$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  // exact orientation class of r against the directed line p->q
  function automatic orient_t orientation_of(point_t p, point_t q, point_t r);
    longint cross_val;
    cross_val = (longint'(q.y) - longint'(p.y)) * (longint'(r.x) - longint'(q.x))
              - (longint'(q.x) - longint'(p.x)) * (longint'(r.y) - longint'(q.y));
    if (cross_val == 0) return ORIENT_ZERO;
    return (cross_val > 0) ? ORIENT_POS : ORIENT_NEG;
  endfunction

  // m strictly between a and b on one axis, or all three equal
  function automatic bit strictly_between(coord_t a, coord_t m, coord_t b);
    coord_t lo;
    coord_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (m > lo && m < hi) || (m == lo && m == hi);
  endfunction

  function automatic bit lies_within(point_t a, point_t m, point_t b);
    return strictly_between(a.x, m.x, b.x) && strictly_between(a.y, m.y, b.y);
  endfunction

  // expected verdict for one pair of segments
  function automatic logic predict_overlap(seg_pair_t sp);
    orient_t s1;
    orient_t s2;
    orient_t s3;
    orient_t s4;
    bit      first_shared;
    bit      second_shared;
    s1 = orientation_of(sp.a0, sp.a1, sp.b0);
    s2 = orientation_of(sp.a0, sp.a1, sp.b1);
    s3 = orientation_of(sp.b0, sp.b1, sp.a0);
    s4 = orientation_of(sp.b0, sp.b1, sp.a1);
    // proper crossing needs all four signs nonzero
    if (s1 != s2 && s3 != s4) begin
      return s1 != ORIENT_ZERO && s2 != ORIENT_ZERO && s3 != ORIENT_ZERO && s4 != ORIENT_ZERO;
    end
    if (s1 != ORIENT_ZERO || s2 != ORIENT_ZERO || s3 != ORIENT_ZERO || s4 != ORIENT_ZERO) begin
      return 1'b0;
    end
    // collinear: endpoint strictly inside, or same endpoints in either order
    if (lies_within(sp.a0, sp.b0, sp.a1) || lies_within(sp.a0, sp.b1, sp.a1) ||
        lies_within(sp.b0, sp.a0, sp.b1) || lies_within(sp.b0, sp.a1, sp.b1)) begin
      return 1'b1;
    end
    first_shared  = (sp.a0 == sp.b0) || (sp.a0 == sp.b1);
    second_shared = (sp.a1 == sp.b0) || (sp.a1 == sp.b1);
    return first_shared && second_shared;
  endfunction

  function automatic seg_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
                                          int bx0, int by0, int bx1, int by1);
    seg_pair_t sp;
    sp.a0.x = coord_t'(ax0);
    sp.a0.y = coord_t'(ay0);
    sp.a1.x = coord_t'(ax1);
    sp.a1.y = coord_t'(ay1);
    sp.b0.x = coord_t'(bx0);
    sp.b0.y = coord_t'(by0);
    sp.b1.x = coord_t'(bx1);
    sp.b1.y = coord_t'(by1);
    return sp;
  endfunction

  function automatic coord_t span_coord(int lim);
    return coord_t'(int'($urandom_range(2 * lim)) - lim);
  endfunction

  // random pair biased toward collinear, shared-endpoint and corner cases
  function automatic seg_pair_t random_pair();
    seg_pair_t sp;
    point_t    pts [4];
    int        pick;
    int        lim;
    int        base_x;
    int        base_y;
    int        dir_x;
    int        dir_y;
    int        t;
    pick = $urandom_range(99);
    if (pick < 20) begin
      sp = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
      return sp;
    end else if (pick < 45) begin
      for (int i = 0; i < 4; i++) begin
        pts[i].x = span_coord(4);
        pts[i].y = span_coord(4);
      end
    end else if (pick < 75) begin
      // four points on one line, in any order
      base_x = int'(span_coord(1000));
      base_y = int'(span_coord(1000));
      dir_x  = int'($urandom_range(400)) - 200;
      dir_y  = int'($urandom_range(400)) - 200;
      case ($urandom_range(3))
        0: dir_x = 0;
        1: dir_y = 0;
        default: ;
      endcase
      for (int i = 0; i < 4; i++) begin
        t = int'($urandom_range(8)) - 4;
        pts[i].x = coord_t'(base_x + t * dir_x);
        pts[i].y = coord_t'(base_y + t * dir_y);
      end
    end else if (pick < 90) begin
      // segments sharing one or both endpoints
      lim = ($urandom_range(1) == 0) ? 8 : 32767;
      for (int i = 0; i < 4; i++) begin
        pts[i].x = span_coord(lim);
        pts[i].y = span_coord(lim);
      end
      case ($urandom_range(3))
        0: begin
          pts[2] = pts[0];
          pts[3] = pts[1];
        end
        1: begin
          pts[2] = pts[1];
          pts[3] = pts[0];
        end
        2: pts[2] = pts[1];
        default: pts[3] = pts[0];
      endcase
    end else begin
      for (int i = 0; i < 4; i++) begin
        pts[i].x = coord_t'(CORNER_VALUES[$urandom_range(6)]);
        pts[i].y = coord_t'(CORNER_VALUES[$urandom_range(6)]);
      end
    end
    sp.a0 = pts[0];
    sp.a1 = pts[1];
    sp.b0 = pts[2];
    sp.b1 = pts[3];
    return sp;
  endfunction

  // one pair transaction, with random gaps before it; valid stays high afterwards
  task automatic send_pair(input seg_pair_t sp);
    overlap_expect_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      pair_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pair_ch.valid     <= 1'b1;
    pair_ch.a_start_x <= sp.a0.x;
    pair_ch.a_start_y <= sp.a0.y;
    pair_ch.a_end_x   <= sp.a1.x;
    pair_ch.a_end_y   <= sp.a1.y;
    pair_ch.b_start_x <= sp.b0.x;
    pair_ch.b_start_y <= sp.b0.y;
    pair_ch.b_end_x   <= sp.b1.x;
    pair_ch.b_end_y   <= sp.b1.y;
    do @(posedge clk); while (pair_ch.ready !== 1'b1);
    entry.pair    = sp;
    entry.overlap = predict_overlap(sp);
    overlap_expect_q.push_back(entry);
  endtask

  // hold the sender off until every verdict is back
  task automatic drain_results();
    pair_ch.valid <= 1'b0;
    while (overlap_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_crossings();
    send_pair(make_pair(-10, 0, 10, 0, 0, -10, 0, 10));
    send_pair(make_pair(-10, 0, 10, 0, 0, 0, 0, 10));
    send_pair(make_pair(0, 0, 5, 5, 5, 5, 10, 0));
    send_pair(make_pair(0, 0, 10, 0, 0, 1, 10, 1));
    send_pair(make_pair(0, 0, 10, 0, 15, 0, 5, 5));
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(make_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
  endtask

  task automatic test_collinear();
    send_pair(make_pair(0, 0, 10, 0, 5, 0, 15, 0));
    send_pair(make_pair(0, 0, 4, 0, 6, 0, 10, 0));
    send_pair(make_pair(0, 0, 5, 0, 5, 0, 10, 0));
    send_pair(make_pair(1, 2, 7, 9, 1, 2, 7, 9));
    send_pair(make_pair(1, 2, 7, 9, 7, 9, 1, 2));
    send_pair(make_pair(0, 0, 10, 10, 2, 2, 4, 4));
    send_pair(make_pair(3, -5, 3, 5, 3, 0, 3, 9));
    send_pair(make_pair(-32768, -32768, 32767, 32767, -100, -100, 100, 100));
    send_pair(make_pair(-32768, 32767, 32767, 32767, 32767, 32767, -32768, 32767));
  endtask

  task automatic test_degenerate();
    send_pair(make_pair(2, 2, 2, 2, 0, 0, 4, 4));
    send_pair(make_pair(5, -3, 5, -3, 5, -3, 5, -3));
    send_pair(make_pair(0, 0, 0, 0, 1, 1, 1, 1));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    send_pair(make_pair(0, 0, 4, 4, 4, 4, 4, 4));
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_pair(random_pair());
  endtask

  // receiver readiness, random per cycle
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    overlap_expect_t head;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (overlap_expect_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual segments_overlap=%0b",
                 $time, result_ch.segments_overlap);
        error_count++;
      end else begin
        head = overlap_expect_q.pop_front();
        if (result_ch.segments_overlap !== head.overlap) begin
          $display("%0t segments_overlap mismatch for pair %h: expected %0b actual %0b",
                   $time, head.pair, head.overlap, result_ch.segments_overlap);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (pair_ch.valid && pair_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("** segment_crossing_test: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst               <= 1'b1;
    pair_ch.valid     <= 1'b0;
    pair_ch.a_start_x <= '0;
    pair_ch.a_start_y <= '0;
    pair_ch.a_end_x   <= '0;
    pair_ch.a_end_y   <= '0;
    pair_ch.b_start_x <= '0;
    pair_ch.b_start_y <= '0;
    pair_ch.b_end_x   <= '0;
    pair_ch.b_end_y   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // sender idles less than receiver
    send_idle_pct = 33;
    recv_idle_pct = 55;
    test_crossings();
    test_collinear();
    test_degenerate();
    drain_results();
    test_random(400);
    drain_results();

    // receiver idles less than sender
    send_idle_pct = 55;
    recv_idle_pct = 33;
    test_random(400);
    drain_results();

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(350);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("** segment_crossing_test: PASSED **");
    end else begin
      $display("** segment_crossing_test: FAILED **");
    end
    $finish;
  end

endmodule
